// ----- rtl/stb_pkg.sv -----
// Shared types and constants for the software timer bank.
// Word formats, action codes, controller states and the command/status structs.
// No dependencies.
`default_nettype none

package stb_pkg;

    localparam int NUM_TIMERS_DEF  = 8;
    localparam int COUNT_WIDTH_DEF = 16;

    // action codes
    localparam logic [2:0] ACT_TICK   = 3'd0;
    localparam logic [2:0] ACT_CREATE = 3'd1;
    localparam logic [2:0] ACT_DELETE = 3'd2;
    localparam logic [2:0] ACT_START  = 3'd3;
    localparam logic [2:0] ACT_STOP   = 3'd4;

    typedef struct packed {
        logic [2:0]  action;
        logic [2:0]  slot;
        logic [15:0] delay_ticks;
        logic [15:0] period_ticks;
        logic        start_running;
    } cmd_word_t;

    typedef struct packed {
        logic       kind;
        logic [2:0] result_slot;
        logic       ok;
        logic       last;
    } rsp_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REPLY,
        ST_CREATE,
        ST_TK_RD,
        ST_TK_EVAL,
        ST_TK_DONE
    } state_t;

    // slot update applied by the datapath
    typedef enum logic [1:0] {
        UPD_NONE,
        UPD_HANDLE,
        UPD_CREATE,
        UPD_TICK
    } upd_t;

    // response word to build
    typedef enum logic [2:0] {
        RES_REPLY,
        RES_CREATED,
        RES_FULL,
        RES_FIRE,
        RES_DONE
    } res_t;

    typedef struct packed {
        logic load;
        logic idx_inc;
        logic mem_rd;
        upd_t upd;
        logic push;
        res_t res;
    } dp_cmd_t;

    typedef struct packed {
        logic used;
        logic last_idx;
        logic fire;
        logic rsp_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ----- rtl/stb_datapath.sv -----
// Datapath of the software timer bank: slot flags, delay/period memory,
// scan index, captured command word and response register.
// Depends on stb_pkg.
`default_nettype none

module stb_datapath #(
    parameter int NUM_TIMERS  = stb_pkg::NUM_TIMERS_DEF,
    parameter int COUNT_WIDTH = stb_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire stb_pkg::cmd_word_t cmd,
    input  wire stb_pkg::dp_cmd_t   ctl,
    output stb_pkg::dp_status_t     status,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output stb_pkg::rsp_word_t      rsp
);

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    // wide enough for a 3-bit handle and for the slot count itself
    localparam int EXT_W = ((IDX_W + 1) > 3) ? (IDX_W + 1) : 3;
    localparam logic [EXT_W-1:0] LAST_IDX  = EXT_W'(NUM_TIMERS - 1);
    localparam logic [EXT_W-1:0] NUM_SLOTS = EXT_W'(NUM_TIMERS);

    stb_pkg::cmd_word_t     item_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic [IDX_W-1:0]       idx_next;
    logic [NUM_TIMERS-1:0]  in_use_reg;
    logic [NUM_TIMERS-1:0]  in_use_next;
    logic [NUM_TIMERS-1:0]  running_reg;
    logic [NUM_TIMERS-1:0]  running_next;
    logic [COUNT_WIDTH-1:0] rd_delay_reg;
    logic [COUNT_WIDTH-1:0] rd_period_reg;
    logic                   rsp_valid_reg;
    logic                   rsp_valid_next;
    stb_pkg::rsp_word_t     rsp_word_reg;
    stb_pkg::rsp_word_t     rsp_word_next;

    logic [2*COUNT_WIDTH-1:0] row_mem [NUM_TIMERS];
    logic                     mem_we;
    logic [2*COUNT_WIDTH-1:0] mem_wdata;

    logic [EXT_W-1:0]       idx_ext;
    logic [EXT_W-1:0]       handle_ext;
    logic [IDX_W-1:0]       handle_idx;
    logic                   handle_valid;
    logic                   handle_action;
    logic                   delay_zero;
    logic [COUNT_WIDTH-1:0] dly_c;
    logic [COUNT_WIDTH-1:0] per_c;

    assign idx_ext       = EXT_W'(idx_reg);
    assign handle_ext    = EXT_W'(item_reg.slot);
    assign handle_idx    = handle_ext[IDX_W-1:0];
    assign handle_valid  = (handle_ext < NUM_SLOTS) && in_use_reg[handle_idx];
    assign handle_action = item_reg.action inside
                           {stb_pkg::ACT_DELETE, stb_pkg::ACT_START, stb_pkg::ACT_STOP};
    assign delay_zero    = (rd_delay_reg == '0);
    assign dly_c         = COUNT_WIDTH'(item_reg.delay_ticks);
    assign per_c         = COUNT_WIDTH'(item_reg.period_ticks);

    assign status.used     = in_use_reg[idx_reg];
    assign status.last_idx = (idx_ext == LAST_IDX);
    assign status.fire     = in_use_reg[idx_reg] && running_reg[idx_reg] && delay_zero;
    assign status.rsp_free = !rsp_valid_reg || !rsp_stall;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_word_reg;

    // slot state update
    always_comb
    begin
        in_use_next  = in_use_reg;
        running_next = running_reg;
        mem_we       = 1'b0;
        mem_wdata    = '0;
        unique case (ctl.upd)
            stb_pkg::UPD_HANDLE:
            begin
                if (handle_valid)
                begin
                    case (item_reg.action)
                        stb_pkg::ACT_DELETE:
                        begin
                            in_use_next[handle_idx]  = 1'b0;
                            running_next[handle_idx] = 1'b0;
                        end
                        stb_pkg::ACT_START: running_next[handle_idx] = 1'b1;
                        stb_pkg::ACT_STOP:  running_next[handle_idx] = 1'b0;
                        default: ;
                    endcase
                end
            end
            stb_pkg::UPD_CREATE:
            begin
                in_use_next[idx_reg]  = 1'b1;
                running_next[idx_reg] = item_reg.start_running;
                mem_we                = 1'b1;
                mem_wdata             = {per_c, dly_c};
            end
            stb_pkg::UPD_TICK:
            begin
                if (delay_zero)
                begin
                    if (running_reg[idx_reg])
                    begin
                        if (rd_period_reg == '0)
                        begin
                            in_use_next[idx_reg]  = 1'b0;
                            running_next[idx_reg] = 1'b0;
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = {rd_period_reg, rd_period_reg};
                        end
                    end
                end
                else
                begin
                    mem_we    = 1'b1;
                    mem_wdata = {rd_period_reg, rd_delay_reg - COUNT_WIDTH'(1)};
                end
            end
            default: ;
        endcase
    end

    // response word
    always_comb
    begin
        rsp_word_next = rsp_word_reg;
        case (ctl.res)
            stb_pkg::RES_REPLY:
            begin
                rsp_word_next.kind        = 1'b0;
                rsp_word_next.result_slot = handle_action ? item_reg.slot : 3'd0;
                rsp_word_next.ok          = handle_action && handle_valid;
                rsp_word_next.last        = 1'b1;
            end
            stb_pkg::RES_CREATED:
            begin
                rsp_word_next.kind        = 1'b0;
                rsp_word_next.result_slot = idx_ext[2:0];
                rsp_word_next.ok          = 1'b1;
                rsp_word_next.last        = 1'b1;
            end
            stb_pkg::RES_FIRE:
            begin
                rsp_word_next.kind        = 1'b1;
                rsp_word_next.result_slot = idx_ext[2:0];
                rsp_word_next.ok          = 1'b1;
                rsp_word_next.last        = 1'b0;
            end
            stb_pkg::RES_DONE:
            begin
                rsp_word_next.kind        = 1'b0;
                rsp_word_next.result_slot = 3'd0;
                rsp_word_next.ok          = 1'b1;
                rsp_word_next.last        = 1'b1;
            end
            default:
            begin
                rsp_word_next.kind        = 1'b0;
                rsp_word_next.result_slot = 3'd0;
                rsp_word_next.ok          = 1'b0;
                rsp_word_next.last        = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (ctl.load)
        begin
            idx_next = '0;
        end
        else if (ctl.idx_inc)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (ctl.push)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            in_use_reg    <= '0;
            running_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            in_use_reg    <= in_use_next;
            running_reg   <= running_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            item_reg <= cmd;
        end
        if (ctl.push)
        begin
            rsp_word_reg <= rsp_word_next;
        end
    end

    // delay/period memory: one write and one registered read, both at the scan index
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            row_mem[idx_reg] <= mem_wdata;
        end
        if (ctl.mem_rd)
        begin
            {rd_period_reg, rd_delay_reg} <= row_mem[idx_reg];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/stb_ctrl.sv -----
// Controller of the software timer bank: sequences replies, the create
// search and the tick scan. Depends on stb_pkg.
`default_nettype none

module stb_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cmd_valid,
    output logic                     cmd_stall,
    input  wire logic [2:0]          cmd_action,
    input  wire stb_pkg::dp_status_t status,
    output stb_pkg::dp_cmd_t         ctl
);

    stb_pkg::state_t state_reg;
    stb_pkg::state_t state_next;

    assign cmd_stall = (state_reg != stb_pkg::ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            stb_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd_action)
                        stb_pkg::ACT_TICK:   state_next = stb_pkg::ST_TK_RD;
                        stb_pkg::ACT_CREATE: state_next = stb_pkg::ST_CREATE;
                        default:             state_next = stb_pkg::ST_REPLY;
                    endcase
                end
            end
            stb_pkg::ST_REPLY:
            begin
                if (status.rsp_free)
                begin
                    state_next = stb_pkg::ST_IDLE;
                end
            end
            stb_pkg::ST_CREATE:
            begin
                if ((!status.used || status.last_idx) && status.rsp_free)
                begin
                    state_next = stb_pkg::ST_IDLE;
                end
            end
            stb_pkg::ST_TK_RD:
            begin
                if (status.used)
                begin
                    state_next = stb_pkg::ST_TK_EVAL;
                end
                else if (status.last_idx)
                begin
                    state_next = stb_pkg::ST_TK_DONE;
                end
            end
            stb_pkg::ST_TK_EVAL:
            begin
                if (!status.fire || status.rsp_free)
                begin
                    state_next = status.last_idx ? stb_pkg::ST_TK_DONE : stb_pkg::ST_TK_RD;
                end
            end
            stb_pkg::ST_TK_DONE:
            begin
                if (status.rsp_free)
                begin
                    state_next = stb_pkg::ST_IDLE;
                end
            end
            default: state_next = stb_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctl.load    = 1'b0;
        ctl.idx_inc = 1'b0;
        ctl.mem_rd  = 1'b0;
        ctl.upd     = stb_pkg::UPD_NONE;
        ctl.push    = 1'b0;
        ctl.res     = stb_pkg::RES_REPLY;
        unique case (state_reg)
            stb_pkg::ST_IDLE:
            begin
                ctl.load = cmd_valid;
            end
            stb_pkg::ST_REPLY:
            begin
                if (status.rsp_free)
                begin
                    ctl.upd  = stb_pkg::UPD_HANDLE;
                    ctl.push = 1'b1;
                end
            end
            stb_pkg::ST_CREATE:
            begin
                if (!status.used)
                begin
                    if (status.rsp_free)
                    begin
                        ctl.upd  = stb_pkg::UPD_CREATE;
                        ctl.push = 1'b1;
                        ctl.res  = stb_pkg::RES_CREATED;
                    end
                end
                else if (status.last_idx)
                begin
                    ctl.push = status.rsp_free;
                    ctl.res  = stb_pkg::RES_FULL;
                end
                else
                begin
                    ctl.idx_inc = 1'b1;
                end
            end
            stb_pkg::ST_TK_RD:
            begin
                if (status.used)
                begin
                    ctl.mem_rd = 1'b1;
                end
                else
                begin
                    ctl.idx_inc = !status.last_idx;
                end
            end
            stb_pkg::ST_TK_EVAL:
            begin
                ctl.res = stb_pkg::RES_FIRE;
                if (!status.fire || status.rsp_free)
                begin
                    ctl.upd     = stb_pkg::UPD_TICK;
                    ctl.push    = status.fire;
                    ctl.idx_inc = !status.last_idx;
                end
            end
            stb_pkg::ST_TK_DONE:
            begin
                ctl.push = status.rsp_free;
                ctl.res  = stb_pkg::RES_DONE;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= stb_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/software_timer_bank_core.sv -----
// Top level of the software timer bank: joins the controller and the datapath.
// Depends on stb_pkg, stb_ctrl and stb_datapath.
//
// A bank of NUM_TIMERS timer slots, each with an in-use bit, a run bit, a
// COUNT_WIDTH-bit delay and a period; all slots are free after reset. One
// command word is taken at a time and is answered by response words on the
// rsp channel, the final one marked last. Create takes the lowest free slot
// and returns it (ok 0 when the bank is full); delete, start and stop act on
// a slot handle and answer ok 0 for an unused or out-of-range handle. A tick
// visits the used slots in ascending order: a running slot at zero delay
// fires and is freed (zero period) or reloaded from its period, a stopped
// slot at zero waits, any other slot counts down by one. The fire words come
// first, then a done word. Delete, start, stop and unknown actions are answered
// from a reply state; create searches the slots in ascending order, up to
// NUM_TIMERS of them; a tick visits every slot, free or used, and a used slot
// is read and then written back (the delay/period memory has one registered
// read port), before the done word is built. A held response register sits
// on rsp, so a new command is accepted while the last word of the previous
// one still waits; any further word waits on rsp_stall.
`default_nettype none

module software_timer_bank_core #(
    parameter int NUM_TIMERS  = stb_pkg::NUM_TIMERS_DEF,
    parameter int COUNT_WIDTH = stb_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    output logic                    cmd_stall,
    input  wire stb_pkg::cmd_word_t cmd,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output stb_pkg::rsp_word_t      rsp
);

    // command and status between the sequencer and the slot datapath
    stb_pkg::dp_cmd_t    ctl;
    stb_pkg::dp_status_t status;

    stb_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd_action (cmd.action),
        .status     (status),
        .ctl        (ctl)
    );

    stb_datapath #(
        .NUM_TIMERS  (NUM_TIMERS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .ctl       (ctl),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

// ----- tb/software_timer_bank_core_tb.sv -----
// Self-checking testbench for software_timer_bank_core: directed and random command
// words, a class-based scoreboard that predicts the response words.
// Depends on stb_pkg and the software_timer_bank_core RTL.
`default_nettype none

module software_timer_bank_core_tb;

    localparam int NUM_TIMERS  = stb_pkg::NUM_TIMERS_DEF;
    localparam int RANDOM_WORDS = 144;
    localparam int HOLD_CYCLES = 300;   // long receiver hold-off
    localparam int STALL_LIMIT = 3000;  // cycles with no handshake before giving up
    localparam int TAIL_CYCLES = 4 * NUM_TIMERS + 8;

    // actions beyond stop are reserved; the block answers them with a bare status
    localparam logic [2:0] ACT_RESERVED_FIRST = stb_pkg::ACT_STOP + 3'd1;
    localparam logic [2:0] ACT_RESERVED_LAST  = 3'd7;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_FIRE   = 1'b1;

    // Predicts the response words of the timer bank and checks them in order.
    class timer_bank_scoreboard;
        bit                 in_use  [NUM_TIMERS];
        bit                 running [NUM_TIMERS];
        logic [15:0]        delay   [NUM_TIMERS];
        logic [15:0]        period  [NUM_TIMERS];
        stb_pkg::rsp_word_t awaited_words[$];
        int                 error_count;

        function void push_word(logic kind, logic [2:0] s, logic ok, logic last);
            stb_pkg::rsp_word_t r;
            r.kind        = kind;
            r.result_slot = s;
            r.ok          = ok;
            r.last        = last;
            awaited_words.push_back(r);
        endfunction

        function void free_slot(int i);
            in_use[i]  = 1'b0;
            running[i] = 1'b0;
            delay[i]   = '0;
            period[i]  = '0;
        endfunction

        function void note_command(stb_pkg::cmd_word_t w);
            bit handle_used;
            bit placed;
            handle_used = (int'(w.slot) < NUM_TIMERS) && in_use[w.slot];
            placed      = 1'b0;
            case (w.action)
                stb_pkg::ACT_TICK:
                begin
                    for (int i = 0; i < NUM_TIMERS; i++)
                    begin
                        if (in_use[i])
                        begin
                            if (delay[i] != 0)
                                delay[i] = delay[i] - 16'd1;
                            else if (running[i])
                            begin
                                push_word(KIND_FIRE, 3'(i), 1'b1, 1'b0);
                                if (period[i] == 0)
                                    free_slot(i);
                                else
                                    delay[i] = period[i];
                            end
                        end
                    end
                    push_word(KIND_STATUS, 3'd0, 1'b1, 1'b1);
                end
                stb_pkg::ACT_CREATE:
                begin
                    for (int i = 0; i < NUM_TIMERS && !placed; i++)
                    begin
                        if (!in_use[i])
                        begin
                            in_use[i]  = 1'b1;
                            running[i] = w.start_running;
                            delay[i]   = w.delay_ticks;
                            period[i]  = w.period_ticks;
                            placed     = 1'b1;
                            push_word(KIND_STATUS, 3'(i), 1'b1, 1'b1);
                        end
                    end
                    if (!placed)
                        push_word(KIND_STATUS, 3'd0, 1'b0, 1'b1);
                end
                stb_pkg::ACT_DELETE:
                begin
                    if (handle_used)
                        free_slot(w.slot);
                    push_word(KIND_STATUS, w.slot, handle_used, 1'b1);
                end
                stb_pkg::ACT_START, stb_pkg::ACT_STOP:
                begin
                    if (handle_used)
                        running[w.slot] = (w.action == stb_pkg::ACT_START);
                    push_word(KIND_STATUS, w.slot, handle_used, 1'b1);
                end
                default:
                    push_word(KIND_STATUS, 3'd0, 1'b0, 1'b1);
            endcase
        endfunction

        function void report_field(string name, int want, int got);
            if (want != got)
            begin
                $display("%0t: response %s mismatch, expected %0d actual %0d",
                         $time, name, want, got);
                error_count++;
            end
        endfunction

        function void check_response(stb_pkg::rsp_word_t got);
            stb_pkg::rsp_word_t want;
            if (awaited_words.size() == 0)
            begin
                $display("%0t: unexpected response word, expected none actual %p", $time, got);
                error_count++;
                return;
            end
            want = awaited_words.pop_front();
            if (^got === 1'bx)
            begin
                $display("%0t: response word unknown, expected %p actual %p", $time, want, got);
                error_count++;
                return;
            end
            report_field("kind", want.kind, got.kind);
            report_field("result_slot", want.result_slot, got.result_slot);
            report_field("ok", want.ok, got.ok);
            report_field("last", want.last, got.last);
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cmd_valid;
    logic               cmd_stall;
    stb_pkg::cmd_word_t cmd;
    logic               rsp_valid;
    logic               rsp_stall;
    stb_pkg::rsp_word_t rsp;

    timer_bank_scoreboard sb;

    bit calm;          // both sides run flat out while set
    bit hold_request;  // asks the receiver for its long hold-off
    int quiet_cycles = 0;

    software_timer_bank_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #10 clk = ~clk;

    // Offer one command word, idling at random first; return just after the edge
    // that took it.
    task automatic send_word(input stb_pkg::cmd_word_t w);
        while (!calm && $urandom_range(99) < 32)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd       <= w;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        sb.note_command(w);
    endtask

    task automatic send_fields(input logic [2:0] action, input logic [2:0] s,
                               input logic [15:0] dly, input logic [15:0] per,
                               input logic run);
        stb_pkg::cmd_word_t w;
        w.action        = action;
        w.slot          = s;
        w.delay_ticks   = dly;
        w.period_ticks  = per;
        w.start_running = run;
        send_word(w);
    endtask

    // Mostly well-formed traffic: short delays so that timers expire, handles
    // across the whole bank, full-range values now and then.
    function automatic stb_pkg::cmd_word_t random_command();
        stb_pkg::cmd_word_t w;
        int                 pick;
        pick            = $urandom_range(99);
        w.slot          = 3'($urandom_range(NUM_TIMERS - 1));
        w.delay_ticks   = 16'($urandom);
        w.period_ticks  = 16'($urandom);
        w.start_running = 1'($urandom);
        if (pick < 35)
            w.action = stb_pkg::ACT_TICK;
        else if (pick < 60)
        begin
            w.action = stb_pkg::ACT_CREATE;
            if ($urandom_range(99) < 80)
                w.delay_ticks = 16'($urandom_range(4));
            pick = $urandom_range(99);
            if (pick < 50)
                w.period_ticks = '0;
            else if (pick < 85)
                w.period_ticks = 16'($urandom_range(4, 1));
            if ($urandom_range(99) < 80)
                w.start_running = 1'b1;
        end
        else if (pick < 70)
            w.action = stb_pkg::ACT_DELETE;
        else if (pick < 80)
            w.action = stb_pkg::ACT_START;
        else if (pick < 94)
            w.action = stb_pkg::ACT_STOP;
        else
            w.action = 3'($urandom_range(ACT_RESERVED_LAST, ACT_RESERVED_FIRST));
        return w;
    endfunction

    // Receiver: stall at random, once hold off for a long stretch so that the
    // response register fills and the block stalls its command side.
    initial
    begin
        bit hold_served;
        hold_served = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_served)
            begin
                hold_served = 1'b1;
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            rsp_stall <= !calm && ($urandom_range(99) < 32);
        end
    end

    // Check every response word taken.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_response(rsp);
    end

    // Watchdog: count cycles in which no word moves on either side.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("software_timer_bank_core verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        sb           = new;
        clk          = 1'b0;
        rst_n        = 1'b0;
        cmd_valid    = 1'b0;
        cmd          = '0;
        rsp_stall    = 1'b0;
        calm         = 1'b0;
        hold_request = 1'b0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // tick on an empty bank: done word only
        send_fields(stb_pkg::ACT_TICK, 3'd0, 16'h0000, 16'h0000, 1'b0);
        // one-shot at zero, extreme stopped timer, short periodic timer
        send_fields(stb_pkg::ACT_CREATE, 3'd7, 16'h0000, 16'h0000, 1'b1);
        send_fields(stb_pkg::ACT_CREATE, 3'd0, 16'hffff, 16'hffff, 1'b0);
        send_fields(stb_pkg::ACT_CREATE, 3'd5, 16'h0001, 16'h0002, 1'b1);
        // first tick fires and frees slot 0, the stopped timer still counts down
        send_fields(stb_pkg::ACT_TICK, 3'd2, 16'hffff, 16'hffff, 1'b1);
        send_fields(stb_pkg::ACT_TICK, 3'd0, 16'h0000, 16'h0000, 1'b0);
        // handle operations on used and unused slots
        send_fields(stb_pkg::ACT_START, 3'd1, 16'h0000, 16'h0000, 1'b0);
        send_fields(stb_pkg::ACT_STOP, 3'd1, 16'h0000, 16'h0000, 1'b0);
        send_fields(stb_pkg::ACT_START, 3'd7, 16'h0000, 16'h0000, 1'b0);
        send_fields(stb_pkg::ACT_STOP, 3'd5, 16'h0000, 16'h0000, 1'b0);
        send_fields(stb_pkg::ACT_DELETE, 3'd0, 16'h0000, 16'h0000, 1'b0);
        // stopped timer at zero waits through a tick
        send_fields(stb_pkg::ACT_CREATE, 3'd0, 16'h0000, 16'h0000, 1'b0);
        send_fields(stb_pkg::ACT_TICK, 3'd0, 16'h0000, 16'h0000, 1'b0);
        // fill the bank with running timers at zero, then overflow it
        for (int i = 0; i < NUM_TIMERS - 3; i++)
            send_fields(stb_pkg::ACT_CREATE, 3'd0, 16'h0000, 16'h0001, 1'b1);
        send_fields(stb_pkg::ACT_CREATE, 3'd0, 16'h0003, 16'h0003, 1'b1);
        send_fields(stb_pkg::ACT_START, 3'd0, 16'h0000, 16'h0000, 1'b0);
        // fire burst on a full bank
        send_fields(stb_pkg::ACT_TICK, 3'd0, 16'h0000, 16'h0000, 1'b0);
        for (int a = ACT_RESERVED_FIRST; a <= ACT_RESERVED_LAST; a++)
            send_fields(3'(a), 3'd6, 16'h5a5a, 16'ha5a5, 1'b1);
        send_fields(stb_pkg::ACT_DELETE, 3'd1, 16'h0000, 16'h0000, 1'b0);
        send_fields(stb_pkg::ACT_DELETE, 3'd0, 16'h0000, 16'h0000, 1'b0);

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            hold_request = (n >= 50);
            calm         = (n >= 100 && n < 140);
            send_word(random_command());
        end
        calm = 1'b0;
        cmd_valid <= 1'b0;

        // drain, then give the block time to show any stray word
        while (sb.awaited_words.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.error_count == 0 && sb.awaited_words.size() == 0)
            $display("software_timer_bank_core verification clean");
        else
            $display("software_timer_bank_core verification failed");
        $finish;
    end

endmodule

`default_nettype wire
